>>> rtl/core/gshc_pkg.sv
// Shared types and constants for the gas sensor heater cycle calibrator.
// No dependencies.
`default_nettype none

package gshc_pkg;

	localparam int KOHM_W  = 24;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int FACT_W  = 16;
	localparam int MS_W    = 20;

	// numerator widths: filter*256 + factor/2 and 9*filter + sample + 5
	localparam int CAL_NUM_W = KOHM_W + 9;
	localparam int EMA_NUM_W = KOHM_W + 4;
	// divide by ten as multiply by ceil(2^31/10) and shift; exact below 2^30
	localparam int EMA_SHIFT = 31;
	localparam logic [EMA_NUM_W-1:0] EMA_RECIP = 28'd214748365;
	localparam logic [EMA_NUM_W-1:0] EMA_ROUND = 28'd5;

	localparam logic [2:0] REG_FACTOR = 3'd0;
	localparam logic [2:0] REG_HEAT   = 3'd1;
	localparam logic [2:0] REG_RDST   = 3'd2;
	localparam logic [2:0] REG_CEND   = 3'd3;
	localparam logic [2:0] REG_RECAL  = 3'd4;

	localparam logic [FACT_W-1:0] FACTOR_RST = 16'd7245;
	localparam logic [MS_W-1:0]   HEAT_RST   = 20'd60000;
	localparam logic [MS_W-1:0]   RDST_RST   = 20'd80000;
	localparam logic [MS_W-1:0]   CEND_RST   = 20'd90000;
	localparam logic [31:0]       RECAL_RST  = 32'd43200;

	typedef struct packed {
		logic [FACT_W-1:0] factor;
		logic [MS_W-1:0]   heat_ms;
		logic [MS_W-1:0]   rdst_ms;
		logic [MS_W-1:0]   cend_ms;
		logic [31:0]       recal_s;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic busy;
	} sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_CALC
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/gshc_div.sv
// Serial restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none

module gshc_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [NUM_W-1:0]      quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   sub;
	logic             ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign sub   = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// zero divisor gives an all-ones quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/gshc_regs.sv
// APB configuration registers of the heater cycle calibrator.
// Depends on gshc_pkg.
`default_nettype none

module gshc_regs
	import gshc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;

	assign idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.factor  <= FACTOR_RST;
			cfg_q.heat_ms <= HEAT_RST;
			cfg_q.rdst_ms <= RDST_RST;
			cfg_q.cend_ms <= CEND_RST;
			cfg_q.recal_s <= RECAL_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_FACTOR: cfg_q.factor  <= pwdata[FACT_W-1:0];
				REG_HEAT:   cfg_q.heat_ms <= pwdata[MS_W-1:0];
				REG_RDST:   cfg_q.rdst_ms <= pwdata[MS_W-1:0];
				REG_CEND:   cfg_q.cend_ms <= pwdata[MS_W-1:0];
				REG_RECAL:  cfg_q.recal_s <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FACTOR: prdata = {{(DATA_W-FACT_W){1'b0}}, cfg_q.factor};
			REG_HEAT:   prdata = {{(DATA_W-MS_W){1'b0}}, cfg_q.heat_ms};
			REG_RDST:   prdata = {{(DATA_W-MS_W){1'b0}}, cfg_q.rdst_ms};
			REG_CEND:   prdata = {{(DATA_W-MS_W){1'b0}}, cfg_q.cend_ms};
			REG_RECAL:  prdata = cfg_q.recal_s;
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/gshc_ctrl.sv
// Controller: accepts a poll word, waits for the divider, commits the result.
// Depends on gshc_pkg.
`default_nettype none

module gshc_ctrl
	import gshc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_CALC;
				end
			end
			ST_CALC: begin
				// output slot must be free or emptying this cycle
				if (!sts.busy && (!out_valid_q || out_ready)) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/gshc_dp.sv
// Datapath: phase timing, filter, calibration state, one serial divider.
// Depends on gshc_pkg and gshc_div.
`default_nettype none

module gshc_dp
	import gshc_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [31:0]       now_ms,
	input  wire logic [31:0]       now_s,
	input  wire logic [KOHM_W-1:0] sample_kohm,
	output logic                   heater_on,
	output logic                   sampled,
	output logic [KOHM_W-1:0]      filtered_kohm,
	output logic [KOHM_W-1:0]      base_kohm,
	output logic                   cycle_done,
	output logic                   recalibrated
);

	localparam logic [KOHM_W-1:0] MAX_RST   = KOHM_W'(90 * (2 ** FRAC_BITS));
	localparam logic [KOHM_W-1:0] EMPTY_LIM = KOHM_W'((2 ** FRAC_BITS + 99) / 100);

	// architectural state
	logic              heating_q;
	logic              reading_q;
	logic [31:0]       phase_q;
	logic [KOHM_W-1:0] filter_q;
	logic [KOHM_W-1:0] max_q;
	logic [KOHM_W-1:0] base_q;
	logic [31:0]       date_q;

	// per-poll latches
	logic                 was_rd_q;
	logic                 done_q;
	logic                 calib_q;
	logic                 empty_q;
	logic [KOHM_W-1:0]    filt_pre_q;
	logic [KOHM_W-1:0]    sample_q;
	logic [31:0]          now_s_q;
	logic [EMA_NUM_W-1:0] ema_num_q;

	// result word
	logic              heater_on_q;
	logic              sampled_q;
	logic [KOHM_W-1:0] filtered_q;
	logic [KOHM_W-1:0] base_out_q;
	logic              done_out_q;
	logic              recal_out_q;

	logic [31:0]            diff;
	logic                   heat_end;
	logic                   rd_start;
	logic                   cyc_end;
	logic                   calib_ok;
	logic [KOHM_W-1:0]      filt_pre;
	logic [CAL_NUM_W-1:0]   cal_num;
	logic [EMA_NUM_W-1:0]   ema_num;
	logic [CAL_NUM_W-1:0]   cal_quot;
	logic [2*EMA_NUM_W-1:0] ema_prod;
	logic                   cal_busy;
	logic [KOHM_W-1:0]      base_nxt;
	logic [KOHM_W-1:0]      filt_nxt;

	assign diff     = now_ms - phase_q;
	assign heat_end = heating_q && (diff > {12'd0, cfg.heat_ms});
	assign rd_start = !heating_q && !reading_q && (diff > {12'd0, cfg.rdst_ms});
	assign cyc_end  = !heating_q && (diff > {12'd0, cfg.cend_ms});
	assign filt_pre = rd_start ? '0 : filter_q;
	assign calib_ok = cyc_end && !(max_q > filt_pre) && !((now_s - date_q) < cfg.recal_s);

	assign cal_num = {1'b0, filt_pre, 8'd0} + CAL_NUM_W'(cfg.factor >> 1);
	assign ema_num = {filt_pre, 3'd0} + EMA_NUM_W'(filt_pre) + EMA_NUM_W'(sample_kohm)
		+ EMA_ROUND;

	gshc_div #(
		.NUM_W (CAL_NUM_W),
		.DEN_W (FACT_W)
	) u_cal_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.accept),
		.num    (cal_num),
		.den    (cfg.factor),
		.busy   (cal_busy),
		.quot   (cal_quot)
	);

	// (9*old + new + 5) / 10 by reciprocal multiply
	assign ema_prod = {{EMA_NUM_W{1'b0}}, ema_num_q} * {{EMA_NUM_W{1'b0}}, EMA_RECIP};

	assign sts.busy = cal_busy;

	// saturate to 24 bits
	assign base_nxt = (cal_quot[CAL_NUM_W-1:KOHM_W] != '0) ? '1 : cal_quot[KOHM_W-1:0];

	always_comb begin
		priority if (!was_rd_q) begin
			filt_nxt = filt_pre_q;
		end else if (empty_q) begin
			filt_nxt = sample_q;
		end else begin
			filt_nxt = ema_prod[EMA_SHIFT+KOHM_W-1:EMA_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heating_q <= 1'b1;
			reading_q <= 1'b0;
			phase_q   <= '0;
			filter_q  <= '0;
			max_q     <= MAX_RST;
			base_q    <= '0;
			date_q    <= '0;
		end else begin
			if (cmd.accept) begin
				if (heat_end) begin
					heating_q <= 1'b0;
					reading_q <= 1'b0;
					phase_q   <= now_ms;
				end else if (cyc_end) begin
					heating_q <= 1'b1;
					reading_q <= 1'b0;
					phase_q   <= now_ms;
				end else if (rd_start) begin
					reading_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				filter_q <= filt_nxt;
				if (calib_q) begin
					max_q  <= filt_pre_q;
					base_q <= base_nxt;
					date_q <= now_s_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			was_rd_q   <= reading_q;
			done_q     <= cyc_end;
			calib_q    <= calib_ok;
			empty_q    <= filt_pre < EMPTY_LIM;
			filt_pre_q <= filt_pre;
			sample_q   <= sample_kohm;
			now_s_q    <= now_s;
			ema_num_q  <= ema_num;
		end
		if (cmd.commit) begin
			heater_on_q <= heating_q;
			sampled_q   <= was_rd_q;
			filtered_q  <= filt_nxt;
			base_out_q  <= calib_q ? base_nxt : base_q;
			done_out_q  <= done_q;
			recal_out_q <= calib_q;
		end
	end

	assign heater_on     = heater_on_q;
	assign sampled       = sampled_q;
	assign filtered_kohm = filtered_q;
	assign base_kohm     = base_out_q;
	assign cycle_done    = done_out_q;
	assign recalibrated  = recal_out_q;

endmodule

`default_nettype wire

>>> rtl/core/gas_sensor_heater_cycle_calibrator.sv
// Gas sensor heater cycle calibrator: heater phases, EMA filter, base calibration.
// Each accepted poll runs through the 33-bit serial divider before its result word is committed.
// One poll at a time; the next poll is taken while a result waits.
// Reset: asynchronous, active low; registers return to defaults, heater on.
// Depends on gshc_pkg, gshc_regs, gshc_ctrl, gshc_dp, gshc_div.
`default_nettype none

module gas_sensor_heater_cycle_calibrator
	import gshc_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [31:0]       now_ms,
	input  wire logic [31:0]       now_s,
	input  wire logic [KOHM_W-1:0] sample_kohm,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   heater_on,
	output logic                   sampled,
	output logic [KOHM_W-1:0]      filtered_kohm,
	output logic [KOHM_W-1:0]      base_kohm,
	output logic                   cycle_done,
	output logic                   recalibrated
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	gshc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	gshc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gshc_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.now_ms        (now_ms),
		.now_s         (now_s),
		.sample_kohm   (sample_kohm),
		.heater_on     (heater_on),
		.sampled       (sampled),
		.filtered_kohm (filtered_kohm),
		.base_kohm     (base_kohm),
		.cycle_done    (cycle_done),
		.recalibrated  (recalibrated)
	);

endmodule

`default_nettype wire

>>> tb/tb_gas_sensor_heater_cycle_calibrator.sv
// Self-checking testbench for the gas sensor heater cycle calibrator: heater phases,
// EMA filtering and base calibration are predicted per poll and compared field by field.
// Depends on gshc_pkg and the gas_sensor_heater_cycle_calibrator RTL.
module tb_gas_sensor_heater_cycle_calibrator;
	timeunit 1ns;
	timeprecision 1ps;

	import gshc_pkg::*;

	localparam int FRAC_BITS = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 80;
	localparam int N_PHASES = 9;

	typedef struct packed {
		logic              heat;
		logic              samp;
		logic [KOHM_W-1:0] filt;
		logic [KOHM_W-1:0] base;
		logic              done;
		logic              recal;
	} poll_res_t;

	typedef struct {
		bit                is_cfg;
		logic [2:0]        reg_idx;
		logic [31:0]       wdata;
		logic [31:0]       ms;
		logic [31:0]       sec;
		logic [KOHM_W-1:0] smp;
		bit                typed;
		poll_res_t         want;
	} vec_t;

	typedef struct {
		logic [31:0] factor;
		logic [31:0] heat;
		logic [31:0] rdst;
		logic [31:0] cend;
		logic [31:0] recal;
		int          n;
		bit          burst;
	} phase_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [31:0]       now_ms = '0;
	logic [31:0]       now_s = '0;
	logic [KOHM_W-1:0] sample_kohm = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              heater_on;
	logic              sampled;
	logic [KOHM_W-1:0] filtered_kohm;
	logic [KOHM_W-1:0] base_kohm;
	logic              cycle_done;
	logic              recalibrated;

	gas_sensor_heater_cycle_calibrator #(.FRAC_BITS(FRAC_BITS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.now_ms(now_ms), .now_s(now_s), .sample_kohm(sample_kohm),
		.out_valid(out_valid), .out_ready(out_ready),
		.heater_on(heater_on), .sampled(sampled), .filtered_kohm(filtered_kohm),
		.base_kohm(base_kohm), .cycle_done(cycle_done), .recalibrated(recalibrated)
	);

	// settings copy
	logic [FACT_W-1:0] c_factor = FACTOR_RST;
	logic [MS_W-1:0]   c_heat = HEAT_RST;
	logic [MS_W-1:0]   c_rdst = RDST_RST;
	logic [MS_W-1:0]   c_cend = CEND_RST;
	logic [31:0]       c_recal = RECAL_RST;

	// heater and filter state
	logic              m_heating = 1'b1;
	logic              m_reading = 1'b0;
	logic [31:0]       m_phase_start = '0;
	logic [KOHM_W-1:0] m_filter = '0;
	logic [KOHM_W-1:0] m_max = KOHM_W'(90 << FRAC_BITS);
	logic [KOHM_W-1:0] m_base = '0;
	logic [31:0]       m_cal_date = '0;

	poll_res_t expected_polls[$];
	vec_t      plan[$];
	phase_t    phases[N_PHASES];

	int unsigned cycle_cnt = 0;
	int errors = 0;
	int polls_sent = 0;
	int results_checked = 0;
	int cycles_ended = 0;
	int recals = 0;
	bit no_idle = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt == CYCLE_LIMIT);
		$display("%0t timeout with %0d result words outstanding", $time, expected_polls.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic bit stall_roll();
		return !no_idle && ($urandom_range(0, 99) < 30);
	endfunction

	function automatic poll_res_t heater_step(logic [31:0] ms, logic [31:0] sec,
			logic [KOHM_W-1:0] smp);
		poll_res_t r;
		logic [31:0] elapsed;
		logic was_rd;
		logic [63:0] acc;
		r = '0;
		elapsed = ms - m_phase_start;
		was_rd = m_reading;
		if (m_heating) begin
			if (elapsed > 32'(c_heat)) begin
				m_heating = 1'b0;
				m_reading = 1'b0;
				m_phase_start = ms;
			end
		end else begin
			if (!m_reading && elapsed > 32'(c_rdst)) begin
				m_reading = 1'b1;
				m_filter = '0;
			end
			if (elapsed > 32'(c_cend)) begin
				m_heating = 1'b1;
				m_reading = 1'b0;
				m_phase_start = ms;
				r.done = 1'b1;
				if (m_max <= m_filter && (sec - m_cal_date) >= c_recal) begin
					m_max = m_filter;
					if (c_factor == '0) begin
						m_base = '1;
					end else begin
						acc = (64'(m_filter) * 64'd256 + 64'(c_factor >> 1)) / 64'(c_factor);
						m_base = (acc > 64'hFFFFFF) ? '1 : acc[KOHM_W-1:0];
					end
					m_cal_date = sec;
					r.recal = 1'b1;
				end
			end
		end
		if (was_rd) begin
			if (64'(m_filter) * 64'd100 < (64'd1 << FRAC_BITS)) begin
				m_filter = smp;
			end else begin
				acc = (64'(m_filter) * 64'd9 + 64'(smp) + 64'd5) / 64'd10;
				m_filter = acc[KOHM_W-1:0];
			end
		end
		r.heat = m_heating;
		r.samp = was_rd;
		r.filt = m_filter;
		r.base = m_base;
		return r;
	endfunction

	task automatic send_poll(input logic [31:0] ms, input logic [31:0] sec,
			input logic [KOHM_W-1:0] smp, input bit typed, input poll_res_t typed_res);
		poll_res_t pred;
		while (stall_roll()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= ms;
		now_s <= sec;
		sample_kohm <= smp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = heater_step(ms, sec, smp);
		expected_polls.push_back(typed ? typed_res : pred);
		polls_sent++;
		cycles_ended += pred.done;
		recals += pred.recal;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_polls.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FACTOR: c_factor = val[FACT_W-1:0];
			REG_HEAT:   c_heat = val[MS_W-1:0];
			REG_RDST:   c_rdst = val[MS_W-1:0];
			REG_CEND:   c_cend = val[MS_W-1:0];
			REG_RECAL:  c_recal = val;
			default: ;
		endcase
	endtask

	function automatic vec_t poll(logic [31:0] ms, logic [31:0] sec, logic [KOHM_W-1:0] smp);
		vec_t v;
		v = '{default: '0};
		v.ms = ms;
		v.sec = sec;
		v.smp = smp;
		return v;
	endfunction

	function automatic vec_t poll_chk(logic [31:0] ms, logic [31:0] sec,
			logic [KOHM_W-1:0] smp, poll_res_t want);
		vec_t v;
		v = poll(ms, sec, smp);
		v.typed = 1'b1;
		v.want = want;
		return v;
	endfunction

	function automatic vec_t cfg(logic [2:0] idx, logic [31:0] val);
		vec_t v;
		v = '{default: '0};
		v.is_cfg = 1'b1;
		v.reg_idx = idx;
		v.wdata = val;
		return v;
	endfunction

	task automatic check_field(input string name, input logic [KOHM_W-1:0] want,
			input logic [KOHM_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		poll_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_polls.size() == 0) begin
				errors++;
				$display("%0t unexpected result word: expected none, actual filt %0h base %0h",
					$time, filtered_kohm, base_kohm);
			end else begin
				want = expected_polls.pop_front();
				results_checked++;
				check_field("heater_on", want.heat, heater_on);
				check_field("sampled", want.samp, sampled);
				check_field("filtered_kohm", want.filt, filtered_kohm);
				check_field("base_kohm", want.base, base_kohm);
				check_field("cycle_done", want.done, cycle_done);
				check_field("recalibrated", want.recal, recalibrated);
			end
		end
	end

	always @(posedge clk) out_ready <= !stall_roll();

	initial begin
		logic [31:0] ms_cur, s_cur, ms, sec, span, s_span;
		logic [KOHM_W-1:0] smp;
		int total, k;

		// directed: defaults, filter corner cases, wrap, zero factor, zero heat and read-start periods
		plan.push_back(poll_chk(32'd0, 32'd0, 24'hFFFFFF, '{1'b1, 1'b0, 24'd0, 24'd0, 1'b0, 1'b0}));
		plan.push_back(poll_chk(32'd60000, 32'd1, 24'd0, '{1'b1, 1'b0, 24'd0, 24'd0, 1'b0, 1'b0}));
		plan.push_back(poll_chk(32'd60001, 32'd2, 24'h123456,
			'{1'b0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b0}));
		plan.push_back(poll_chk(32'd140001, 32'd3, 24'd5, '{1'b0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b0}));
		plan.push_back(poll_chk(32'd140002, 32'd4, 24'd7, '{1'b0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b0}));
		plan.push_back(poll_chk(32'd140003, 32'd5, 24'd2, '{1'b0, 1'b1, 24'd2, 24'd0, 1'b0, 1'b0}));
		plan.push_back(poll_chk(32'd140004, 32'd6, 24'd3, '{1'b0, 1'b1, 24'd3, 24'd0, 1'b0, 1'b0}));
		plan.push_back(poll_chk(32'd140005, 32'd7, 24'd100,
			'{1'b0, 1'b1, 24'd13, 24'd0, 1'b0, 1'b0}));
		plan.push_back(poll_chk(32'd140006, 32'd8, 24'hFFFFFF,
			'{1'b0, 1'b1, 24'd1677733, 24'd0, 1'b0, 1'b0}));
		plan.push_back(poll(32'd150001, 32'd9, 24'hFFFFFF));
		plan.push_back(poll(32'd150002, 32'd43199, 24'd1234));
		plan.push_back(poll(32'd210003, 32'd43200, 24'd0));
		plan.push_back(poll(32'd290004, 32'd43300, 24'd0));
		plan.push_back(poll(32'd290005, 32'd43400, 24'd24576));
		plan.push_back(poll(32'd300004, 32'd50000, 24'hABCDEF));
		plan.push_back(poll(32'hFFFFFFFF, 32'hFFFFFFFF, 24'd0));
		plan.push_back(poll(32'd80001, 32'd0, 24'd0));
		plan.push_back(poll(32'd80002, 32'd0, 24'd100));
		plan.push_back(poll(32'd90000, 32'd0, 24'd100));
		plan.push_back(cfg(REG_FACTOR, 32'd0));
		plan.push_back(cfg(REG_HEAT, 32'd0));
		plan.push_back(cfg(REG_RDST, 32'd0));
		plan.push_back(cfg(REG_CEND, 32'd2));
		plan.push_back(cfg(REG_RECAL, 32'd0));
		plan.push_back(poll(32'd90001, 32'd0, 24'd0));
		plan.push_back(poll(32'd90002, 32'd0, 24'd0));
		plan.push_back(poll(32'd90003, 32'd0, 24'd24576));
		plan.push_back(poll_chk(32'd90004, 32'd0, 24'd0,
			'{1'b1, 1'b1, 24'd22118, 24'hFFFFFF, 1'b1, 1'b1}));
		plan.push_back(poll_chk(32'd90004, 32'd1, 24'd0,
			'{1'b1, 1'b0, 24'd22118, 24'hFFFFFF, 1'b0, 1'b0}));

		phases[0] = '{32'd7245, 32'd60000, 32'd80000, 32'd90000, 32'd43200, 300, 1'b0};
		phases[1] = '{'1, '1, '1, '1, '1, 150, 1'b0};
		phases[2] = '{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 100, 1'b0};
		phases[3] = '{32'd1, 32'd0, 32'd0, 32'd3, 32'd0, 150, 1'b0};
		phases[4] = '{32'd256, 32'd20, 32'd10, 32'd40, 32'd60, 300, 1'b1};
		for (int p = 5; p < N_PHASES; p++)
			phases[p] = '{$urandom_range(1, 65535), $urandom_range(0, 300),
				$urandom_range(0, 300), $urandom_range(0, 400), $urandom_range(0, 2000),
				220, 1'b0};
		total = 0;
		foreach (phases[p]) total += phases[p].n;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				apb_write(plan[i].reg_idx, plan[i].wdata);
			end else begin
				send_poll(plan[i].ms, plan[i].sec, plan[i].smp, plan[i].typed, plan[i].want);
			end
		end

		k = 0;
		foreach (phases[p]) begin
			drain();
			apb_write(REG_FACTOR, phases[p].factor);
			apb_write(REG_HEAT, phases[p].heat);
			apb_write(REG_RDST, phases[p].rdst);
			apb_write(REG_CEND, phases[p].cend);
			apb_write(REG_RECAL, phases[p].recal);
			no_idle = phases[p].burst;
			ms_cur = $urandom();
			s_cur = $urandom();
			span = (32'(c_heat) + 32'(c_cend)) / 5 + 1;
			s_span = (c_recal > 32'h00100000) ? 32'h00100000 : c_recal / 4 + 3;
			for (int j = 0; j < phases[p].n; j++) begin
				ms_cur += $urandom_range(0, span);
				s_cur += $urandom_range(0, s_span);
				ms = ($urandom_range(0, 99) < 3) ? $urandom() : ms_cur;
				sec = ($urandom_range(0, 99) < 3) ? $urandom() : s_cur;
				// slowly rising level keeps the stored maximum within reach
				if ($urandom_range(0, 99) < 5)
					smp = KOHM_W'($urandom_range(0, 3));
				else
					smp = KOHM_W'((64'(k) * 64'hFFF000) / 64'(total)) +
						KOHM_W'($urandom_range(0, 4095));
				send_poll(ms, sec, smp, 1'b0, '0);
				k++;
			end
			no_idle = 1'b0;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d polls over %0d settings, %0d result words checked", polls_sent,
			N_PHASES + 2, results_checked);
		$display("%0d heater cycles ended, %0d base recalibrations", cycles_ended, recals);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
